[sv/cpu_ready_queue_scheduler_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ready-queue scheduler
// Clocked on clk, disabled during rst.
// ----------------------------------------------------------------------------
`ifndef CPU_READY_QUEUE_SCHEDULER_ASSERT_SVH
`define CPU_READY_QUEUE_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define CRQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/crq_pkg.sv]
// ----------------------------------------------------------------------------
// crq_pkg
// Shared constants, codes and types of the ready-queue scheduler.
// ----------------------------------------------------------------------------
package crq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int MAX_CPUS    = 16;
  localparam int TIME_BITS   = 16;

  localparam int QIDX_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int CPU_IDX_W = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int CPU_CNT_W = $clog2(MAX_CPUS + 1);

  // fixed field widths
  localparam int REQ_W   = 3;
  localparam int CPU_W   = 4;
  localparam int PROC_W  = 8;
  localparam int TLEFT_W = 16;
  localparam int ACT_W   = 3;
  localparam int SLICE_W = 16;
  localparam int MODE_W  = 2;
  localparam int ACTV_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_WAKE      = 3'd0,
    REQ_PREEMPT   = 3'd1,
    REQ_YIELD     = 3'd2,
    REQ_TERMINATE = 3'd3,
    REQ_IDLE      = 3'd4
  } req_code_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_DISPATCH = 3'd0,
    ACT_GO_IDLE  = 3'd1,
    ACT_PREEMPT  = 3'd2,
    ACT_NOTHING  = 3'd3,
    ACT_FULL     = 3'd4
  } act_code_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_FIFO = 2'd0,
    MODE_RR   = 2'd1,
    MODE_SRTF = 2'd2
  } mode_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCHED_MODE  = 2'd0,
    CFG_SLICE_TICKS = 2'd1,
    CFG_ACTIVE_CPUS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [PROC_W-1:0]    proc;
    logic [TIME_BITS-1:0] tleft;
  } entry_t;

  // queue control from the sequencer
  typedef struct packed {
    logic              push;
    entry_t            push_data;
    logic              pop;
    logic [QIDX_W-1:0] pop_idx;
    logic [QIDX_W-1:0] rd_addr;
  } qctl_t;

endpackage

[sv/crq_req_if.sv]
// ----------------------------------------------------------------------------
// crq_req_if
// Scheduler event request channel.
// ----------------------------------------------------------------------------
interface crq_req_if import crq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [CPU_W-1:0]   cpu_index;
  logic [PROC_W-1:0]  proc_id;
  logic [TLEFT_W-1:0] time_left;

  modport source (output valid, req_type, cpu_index, proc_id, time_left, input ready);
  modport sink   (input valid, req_type, cpu_index, proc_id, time_left, output ready);
endinterface

[sv/crq_res_if.sv]
// ----------------------------------------------------------------------------
// crq_res_if
// Scheduler decision result channel.
// ----------------------------------------------------------------------------
interface crq_res_if import crq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [CPU_W-1:0]   target_cpu;
  logic [PROC_W-1:0]  run_proc;
  logic [SLICE_W-1:0] run_slice;

  modport source (output valid, action, target_cpu, run_proc, run_slice, input ready);
  modport sink   (input valid, action, target_cpu, run_proc, run_slice, output ready);
endinterface

[sv/crq_cfg_if.sv]
// ----------------------------------------------------------------------------
// crq_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
interface crq_cfg_if import crq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/cpu_ready_queue_scheduler.sv]
// ----------------------------------------------------------------------------
// cpu_ready_queue_scheduler
// FIFO / round robin / SRTF dispatcher over a shared ready queue.
// ----------------------------------------------------------------------------
//   port  dir   handshake      contents
//   req   in    valid/ready    req_type, cpu_index, proc_id, time_left
//   res   out   valid/ready    action, target_cpu, run_proc, run_slice
//   cfg   in    valid/ready    index, data (always ready)
//
// One request at a time. A wake-up goes through S_EVAL, then S_CPU_SCAN
// under SRTF, to S_OUT; a dispatch decision goes through S_EVAL, S_DECIDE,
// S_Q_SCAN under SRTF, S_REMOVE and S_OUT. The SRTF scans walk the CPU
// table and the queue one entry per cycle.
// A result waits in the output register; a new request is taken meanwhile.
// rst is synchronous; the queue and CPU table need no clearing pass.
`include "cpu_ready_queue_scheduler_assert.svh"

module cpu_ready_queue_scheduler import crq_pkg::*; (
  input logic       clk,
  input logic       rst,
  crq_req_if.sink   req,
  crq_res_if.source res,
  crq_cfg_if.sink   cfg
);
  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_CPU_SCAN, S_DECIDE, S_Q_SCAN, S_REMOVE, S_OUT
  } state_t;

  state_t state;

  logic [MODE_W-1:0]  sched_mode;
  logic [SLICE_W-1:0] slice_ticks;
  logic [ACTV_W-1:0]  active_cpus;

  logic [REQ_W-1:0]     r_type;
  logic [CPU_W-1:0]     r_cpu;
  logic [PROC_W-1:0]    r_proc;
  logic [TIME_BITS-1:0] r_time;

  logic [CPU_CNT_W-1:0] ci;
  logic [QCNT_W-1:0]    qi;
  logic [QIDX_W-1:0]    pick;
  logic [TIME_BITS-1:0] best;
  logic [CPU_IDX_W-1:0] num;
  logic                 found;

  logic [ACT_W-1:0]   p_act;
  logic [CPU_W-1:0]   p_cpu;
  logic [PROC_W-1:0]  p_proc;
  logic [SLICE_W-1:0] p_slice;

  logic                 cpu_busy [MAX_CPUS];
  logic [PROC_W-1:0]    cpu_proc [MAX_CPUS];
  logic [TIME_BITS-1:0] cpu_time [MAX_CPUS];

  qctl_t             q_ctl;
  logic [QCNT_W-1:0] q_count;
  entry_t            q_rd;

  crq_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctl     (q_ctl),
    .count   (q_count),
    .rd_data (q_rd)
  );

  logic                 q_full, cpu_ok, srtf;
  logic [CPU_IDX_W-1:0] cpu_addr, cpu_rd_addr;
  logic [CPU_CNT_W-1:0] n_scan;
  logic                 rd_busy;
  logic [PROC_W-1:0]    rd_proc;
  logic [TIME_BITS-1:0] rd_time;

  assign q_full   = (q_count == QCNT_W'(QUEUE_DEPTH));
  assign cpu_ok   = (32'(r_cpu) < MAX_CPUS);
  assign srtf     = (sched_mode == MODE_SRTF);
  assign cpu_addr = CPU_IDX_W'(r_cpu);
  assign n_scan   = (32'(active_cpus) > MAX_CPUS) ? CPU_CNT_W'(MAX_CPUS)
                                                  : CPU_CNT_W'(active_cpus);
  assign cpu_rd_addr = (state == S_CPU_SCAN) ? CPU_IDX_W'(ci) : cpu_addr;
  assign rd_busy  = cpu_busy[cpu_rd_addr];
  assign rd_proc  = cpu_proc[cpu_rd_addr];
  assign rd_time  = cpu_time[cpu_rd_addr];

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  // queue control
  always_comb begin
    q_ctl = '0;
    q_ctl.pop_idx = pick;
    unique case (state)
      S_EVAL: begin
        if (r_type == REQ_WAKE) begin
          q_ctl.push      = !q_full;
          q_ctl.push_data = '{proc: r_proc, tleft: r_time};
        end else if (r_type == REQ_PREEMPT && cpu_ok && rd_busy) begin
          q_ctl.push      = !q_full;
          q_ctl.push_data = '{proc: rd_proc, tleft: rd_time};
        end
      end
      S_Q_SCAN: q_ctl.rd_addr = QIDX_W'(qi);
      S_REMOVE: begin
        q_ctl.rd_addr = pick;
        q_ctl.pop     = 1'b1;
      end
      default: q_ctl.rd_addr = '0;
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sched_mode  <= MODE_FIFO;
      slice_ticks <= SLICE_W'(1);
      active_cpus <= ACTV_W'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_SCHED_MODE:  sched_mode  <= cfg.data[MODE_W-1:0];
        CFG_SLICE_TICKS: slice_ticks <= cfg.data[SLICE_W-1:0];
        CFG_ACTIVE_CPUS: active_cpus <= cfg.data[ACTV_W-1:0];
        default: ;
      endcase
    end
  end

  // CPU table payload
  always_ff @(posedge clk) begin
    if (state == S_REMOVE) begin
      cpu_proc[cpu_addr] <= q_rd.proc;
      cpu_time[cpu_addr] <= q_rd.tleft;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CPUS; i++) cpu_busy[i] <= 1'b0;
    end else if (state == S_EVAL && q_ctl.push && r_type == REQ_PREEMPT) begin
      cpu_busy[cpu_addr] <= 1'b0;
    end else if (state == S_DECIDE && q_count == '0) begin
      cpu_busy[cpu_addr] <= 1'b0;
    end else if (state == S_REMOVE) begin
      cpu_busy[cpu_addr] <= 1'b1;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && state != S_OUT) res.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            r_type <= req.req_type;
            r_cpu  <= req.cpu_index;
            r_proc <= req.proc_id;
            r_time <= TIME_BITS'(req.time_left);
            state  <= S_EVAL;
          end
        end
        S_EVAL: begin
          p_proc  <= '0;
          p_slice <= '0;
          if (r_type == REQ_WAKE) begin
            p_cpu <= '0;
            if (q_full) begin
              p_act <= ACT_FULL;
              state <= S_OUT;
            end else if (srtf) begin
              p_act <= ACT_NOTHING;
              ci    <= '0;
              best  <= r_time;
              found <= 1'b0;
              num   <= '0;
              state <= S_CPU_SCAN;
            end else begin
              p_act <= ACT_NOTHING;
              state <= S_OUT;
            end
          end else if (r_type <= REQ_IDLE && cpu_ok) begin
            if (r_type == REQ_PREEMPT && rd_busy && q_full) begin
              p_act <= ACT_FULL;
              p_cpu <= r_cpu;
              state <= S_OUT;
            end else begin
              p_act <= ACT_NOTHING;
              p_cpu <= '0;
              state <= S_DECIDE;
            end
          end else begin
            p_act <= ACT_NOTHING;
            p_cpu <= '0;
            state <= S_OUT;
          end
        end
        S_CPU_SCAN: begin
          if (ci == n_scan) begin
            if (found) begin
              p_act <= ACT_PREEMPT;
              p_cpu <= CPU_W'(num);
            end
            state <= S_OUT;
          end else if (!rd_busy) begin
            state <= S_OUT;
          end else begin
            if (rd_time > best) begin
              best  <= rd_time;
              num   <= CPU_IDX_W'(ci);
              found <= 1'b1;
            end
            ci <= ci + 1'b1;
          end
        end
        S_DECIDE: begin
          pick <= '0;
          qi   <= QCNT_W'(1);
          best <= q_rd.tleft;
          if (q_count == '0) begin
            p_act <= ACT_GO_IDLE;
            p_cpu <= r_cpu;
            state <= S_OUT;
          end else if (srtf) begin
            state <= S_Q_SCAN;
          end else begin
            state <= S_REMOVE;
          end
        end
        S_Q_SCAN: begin
          if (qi == q_count) begin
            state <= S_REMOVE;
          end else begin
            if (q_rd.tleft < best) begin
              best <= q_rd.tleft;
              pick <= QIDX_W'(qi);
            end
            qi <= qi + 1'b1;
          end
        end
        S_REMOVE: begin
          p_act   <= ACT_DISPATCH;
          p_cpu   <= r_cpu;
          p_proc  <= q_rd.proc;
          p_slice <= (sched_mode == MODE_RR) ? slice_ticks : '0;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (!res.valid || res.ready) begin
            res.valid      <= 1'b1;
            res.action     <= p_act;
            res.target_cpu <= p_cpu;
            res.run_proc   <= p_proc;
            res.run_slice  <= p_slice;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CRQ_ASSERT_IMPL(a_count_bound, 1'b1, q_count <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
  `CRQ_ASSERT_IMPL(a_push_room, q_ctl.push, !q_full, "push into full queue")
  `CRQ_ASSERT_IMPL(a_pop_nonempty, q_ctl.pop, q_count != '0, "pop from empty queue")
  `CRQ_ASSERT_NEXT(a_req_eval, req.valid && req.ready, state == S_EVAL, "request not taken")

endmodule

[sv/crq_cell.sv]
// ----------------------------------------------------------------------------
// crq_cell
// One ready-queue slot: loads a new entry or takes its upper neighbor's.
// ----------------------------------------------------------------------------
module crq_cell import crq_pkg::*; (
  input  logic   clk,
  input  logic   load,
  input  logic   shift,
  input  entry_t din,
  input  entry_t upper,
  output entry_t q
);
  always_ff @(posedge clk) begin
    if (load) begin
      q <= din;
    end else if (shift) begin
      q <= upper;
    end
  end
endmodule

[sv/crq_queue.sv]
// ----------------------------------------------------------------------------
// crq_queue
// Ready queue as a chain of cells with fill count; removal closes the gap.
// ----------------------------------------------------------------------------
module crq_queue import crq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  qctl_t             ctl,
  output logic [QCNT_W-1:0] count,
  output entry_t            rd_data
);
  entry_t cell_q [QUEUE_DEPTH];

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    entry_t upper;
    if (k == QUEUE_DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = cell_q[k+1];
    end
    crq_cell u_cell (
      .clk   (clk),
      .load  (ctl.push && (count == QCNT_W'(k))),
      .shift (ctl.pop && (QIDX_W'(k) >= ctl.pop_idx)),
      .din   (ctl.push_data),
      .upper (upper),
      .q     (cell_q[k])
    );
  end

  assign rd_data = cell_q[ctl.rd_addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.push) begin
      count <= count + 1'b1;
    end else if (ctl.pop) begin
      count <= count - 1'b1;
    end
  end
endmodule
